FILE: design/tcw_pkg.sv
package tcw_pkg;

  // Screen geometry.
  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int CELL_COUNT = ROWS * COLUMNS;

  // Internal widths follow from the geometry.
  localparam int ADDR_W = $clog2(CELL_COUNT);
  localparam int CUR_W  = $clog2(CELL_COUNT + 1);
  localparam int COL_W  = $clog2(COLUMNS);

  // Port field widths.
  localparam int OP_W   = 2;
  localparam int CH_W   = 8;
  localparam int IDX_W  = 11;
  localparam int CELL_W = 2 * CH_W;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
  localparam logic [OP_W-1:0] OP_READ  = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  // Character codes with special handling.
  localparam logic [CH_W-1:0] CH_BACKSPACE = 8'd8;
  localparam logic [CH_W-1:0] CH_TAB       = 8'd9;
  localparam logic [CH_W-1:0] CH_NEWLINE   = 8'd10;
  localparam logic [CH_W-1:0] CH_SPACE     = 8'd32;

  // Command kinds produced by the front end.
  localparam int KIND_W = 3;
  localparam logic [KIND_W-1:0] K_CHAR  = 3'd0;
  localparam logic [KIND_W-1:0] K_TAB   = 3'd1;
  localparam logic [KIND_W-1:0] K_NL    = 3'd2;
  localparam logic [KIND_W-1:0] K_BS    = 3'd3;
  localparam logic [KIND_W-1:0] K_READ  = 3'd4;
  localparam logic [KIND_W-1:0] K_CLEAR = 3'd5;
  localparam logic [KIND_W-1:0] K_NOP   = 3'd6;

  // Queue depth between front and back.
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [CH_W-1:0]   ch;
    logic [CH_W-1:0]   colour;
    logic [ADDR_W-1:0] idx;
    logic              idx_ok;
  } cmd_t;

endpackage

FILE: design/tcw_front.sv
module tcw_front (
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [tcw_pkg::OP_W-1:0] in_operation,
  input  logic [tcw_pkg::CH_W-1:0] in_character,
  input  logic [tcw_pkg::CH_W-1:0] in_colour,
  input  logic [tcw_pkg::IDX_W-1:0] in_cell_index,
  input  logic                     q_full,
  input  logic                     back_init,
  output logic                     q_push,
  output tcw_pkg::cmd_t            q_cmd
);
  import tcw_pkg::*;

  // Hold off items while the queue is full or the screen is being cleared after reset.
  assign in_stall = q_full || back_init;
  assign q_push   = in_valid && !in_stall;

  // Classify the item into a command for the back end.
  always_comb begin
    q_cmd        = '0;
    q_cmd.ch     = in_character;
    q_cmd.colour = in_colour;
    q_cmd.idx    = ADDR_W'(in_cell_index);
    q_cmd.idx_ok = (int'(in_cell_index) < CELL_COUNT);
    case (in_operation)
      OP_PUT: begin
        if (in_character == CH_TAB) begin
          q_cmd.kind = K_TAB;
        end else if (in_character == CH_NEWLINE) begin
          q_cmd.kind = K_NL;
        end else if (in_character == CH_BACKSPACE) begin
          q_cmd.kind = K_BS;
        end else begin
          q_cmd.kind = K_CHAR;
        end
      end
      OP_READ:  q_cmd.kind = K_READ;
      OP_CLEAR: q_cmd.kind = K_CLEAR;
      default:  q_cmd.kind = K_NOP;
    endcase
  end

endmodule

FILE: design/tcw_queue.sv
module tcw_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  tcw_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          empty,
  output tcw_pkg::cmd_t head
);
  import tcw_pkg::*;

  cmd_t              slot_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;

  assign full  = (count_r == QCNT_W'(QDEPTH));
  assign empty = (count_r == '0);
  assign head  = slot_r[rd_ptr_r];

  // Pointer and fill count updates.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (int'(wr_ptr_r) == QDEPTH - 1) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (int'(rd_ptr_r) == QDEPTH - 1) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

FILE: design/tcw_back.sv
module tcw_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      q_empty,
  input  tcw_pkg::cmd_t             q_head,
  output logic                      q_pop,
  output logic                      init_busy,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [tcw_pkg::CH_W-1:0]  out_cell_character,
  output logic [tcw_pkg::CH_W-1:0]  out_cell_colour,
  output logic [tcw_pkg::IDX_W-1:0] out_cursor_position
);
  import tcw_pkg::*;

  localparam int ST_W = 4;
  localparam logic [ST_W-1:0] S_INIT    = 4'd0;
  localparam logic [ST_W-1:0] S_IDLE    = 4'd1;
  localparam logic [ST_W-1:0] S_CHECK   = 4'd2;
  localparam logic [ST_W-1:0] S_SC_RD   = 4'd3;
  localparam logic [ST_W-1:0] S_SC_WR   = 4'd4;
  localparam logic [ST_W-1:0] S_SC_ZERO = 4'd5;
  localparam logic [ST_W-1:0] S_CLR     = 4'd6;
  localparam logic [ST_W-1:0] S_RD_WAIT = 4'd7;
  localparam logic [ST_W-1:0] S_DONE    = 4'd8;

  localparam logic [CUR_W-1:0] LAST_CELL  = CUR_W'(CELL_COUNT - 1);
  localparam logic [CUR_W-1:0] LAST_SHIFT = CUR_W'(CELL_COUNT - COLUMNS - 1);
  localparam logic [CUR_W-1:0] FIRST_ZERO = CUR_W'(CELL_COUNT - COLUMNS);

  logic [ST_W-1:0]   state_r, state_nxt;
  cmd_t              cmd_r, cmd_nxt;
  logic [CUR_W-1:0]  cursor_r, cursor_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [CUR_W-1:0]  cnt_r, cnt_nxt;
  logic [2:0]        reps_r, reps_nxt;
  logic [CH_W-1:0]   res_ch_r, res_ch_nxt;
  logic [CH_W-1:0]   res_col_r, res_col_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [CH_W-1:0]   out_ch_r, out_ch_nxt;
  logic [CH_W-1:0]   out_col_r, out_col_nxt;
  logic [IDX_W-1:0]  out_cur_r, out_cur_nxt;

  logic              mem_we;
  logic [ADDR_W-1:0] mem_wa;
  logic [CELL_W-1:0] mem_wd;
  logic [ADDR_W-1:0] mem_ra;
  logic [CELL_W-1:0] rdata_r;
  logic [CELL_W-1:0] mem [CELL_COUNT];

  logic              slot_free;
  logic [CH_W-1:0]   put_ch;

  assign init_busy           = (state_r == S_INIT);
  assign out_valid           = out_valid_r;
  assign out_cell_character  = out_ch_r;
  assign out_cell_colour     = out_col_r;
  assign out_cursor_position = out_cur_r;
  assign slot_free           = !out_valid_r || !out_stall;
  assign put_ch              = (cmd_r.kind == K_TAB) ? CH_SPACE : cmd_r.ch;

  // Command sequencer: scroll, clear, put and read walk the screen memory.
  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    cursor_nxt    = cursor_r;
    col_nxt       = col_r;
    cnt_nxt       = cnt_r;
    reps_nxt      = reps_r;
    res_ch_nxt    = res_ch_r;
    res_col_nxt   = res_col_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_ch_nxt    = out_ch_r;
    out_col_nxt   = out_col_r;
    out_cur_nxt   = out_cur_r;
    q_pop         = 1'b0;
    mem_we        = 1'b0;
    mem_wa        = ADDR_W'(cnt_r);
    mem_wd        = '0;
    mem_ra        = '0;
    case (state_r)
      S_INIT, S_CLR: begin
        mem_we  = 1'b1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == LAST_CELL) begin
          cursor_nxt = '0;
          col_nxt    = '0;
          state_nxt  = (state_r == S_INIT) ? S_IDLE : S_DONE;
        end
      end
      S_IDLE: begin
        if (!q_empty) begin
          q_pop       = 1'b1;
          cmd_nxt     = q_head;
          res_ch_nxt  = '0;
          res_col_nxt = '0;
          reps_nxt    = (q_head.kind == K_TAB) ? 3'd4 : 3'd1;
          cnt_nxt     = '0;
          case (q_head.kind)
            K_CHAR, K_TAB, K_NL, K_BS: state_nxt = S_CHECK;
            K_READ: begin
              if (q_head.idx_ok) begin
                mem_ra    = q_head.idx;
                state_nxt = S_RD_WAIT;
              end else begin
                state_nxt = S_DONE;
              end
            end
            K_CLEAR: state_nxt = S_CLR;
            default: state_nxt = S_DONE;
          endcase
        end
      end
      S_CHECK: begin
        if (cursor_r == CUR_W'(CELL_COUNT)) begin
          // Cursor sits past the end: scroll up one row first.
          cnt_nxt   = '0;
          state_nxt = S_SC_RD;
        end else begin
          case (cmd_r.kind)
            K_NL: begin
              cursor_nxt = cursor_r + CUR_W'(COLUMNS) - CUR_W'(col_r);
              col_nxt    = '0;
              state_nxt  = S_DONE;
            end
            K_BS: begin
              if (cursor_r != '0) begin
                mem_we     = 1'b1;
                mem_wa     = ADDR_W'(cursor_r - 1'b1);
                mem_wd     = {cmd_r.colour, CH_SPACE};
                cursor_nxt = cursor_r - 1'b1;
                col_nxt    = (col_r == '0) ? COL_W'(COLUMNS - 1) : col_r - 1'b1;
              end
              state_nxt = S_DONE;
            end
            default: begin
              mem_we     = 1'b1;
              mem_wa     = ADDR_W'(cursor_r);
              mem_wd     = {cmd_r.colour, put_ch};
              cursor_nxt = cursor_r + 1'b1;
              col_nxt    = (col_r == COL_W'(COLUMNS - 1)) ? '0 : col_r + 1'b1;
              reps_nxt   = reps_r - 1'b1;
              if (reps_r == 3'd1) begin
                state_nxt = S_DONE;
              end
            end
          endcase
        end
      end
      S_SC_RD: begin
        mem_ra    = ADDR_W'(cnt_r + CUR_W'(COLUMNS));
        state_nxt = S_SC_WR;
      end
      S_SC_WR: begin
        mem_we  = 1'b1;
        mem_wd  = rdata_r;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == LAST_SHIFT) begin
          cnt_nxt   = FIRST_ZERO;
          state_nxt = S_SC_ZERO;
        end else begin
          state_nxt = S_SC_RD;
        end
      end
      S_SC_ZERO: begin
        mem_we  = 1'b1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == LAST_CELL) begin
          cursor_nxt = cursor_r - CUR_W'(COLUMNS);
          state_nxt  = S_CHECK;
        end
      end
      S_RD_WAIT: begin
        res_ch_nxt  = rdata_r[CH_W-1:0];
        res_col_nxt = rdata_r[CELL_W-1:CH_W];
        state_nxt   = S_DONE;
      end
      S_DONE: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_ch_nxt    = res_ch_r;
          out_col_nxt   = res_col_r;
          out_cur_nxt   = IDX_W'(cursor_r);
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      cursor_r    <= '0;
      col_r       <= '0;
      cnt_r       <= '0;
      reps_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cursor_r    <= cursor_nxt;
      col_r       <= col_nxt;
      cnt_r       <= cnt_nxt;
      reps_r      <= reps_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    cmd_r     <= cmd_nxt;
    res_ch_r  <= res_ch_nxt;
    res_col_r <= res_col_nxt;
    out_ch_r  <= out_ch_nxt;
    out_col_r <= out_col_nxt;
    out_cur_r <= out_cur_nxt;
  end

  // Screen memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rdata_r <= mem[mem_ra];
  end

  // The cursor never runs beyond one past the last cell.
  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    cursor_r <= CUR_W'(CELL_COUNT))
    else $error("cursor out of range");

  // The column tracker stays inside a row and is zero whenever the cursor is.
  a_col_home: assert property (@(posedge clk) disable iff (!rst_n)
    (col_r < COL_W'(COLUMNS)) && ((cursor_r != '0) || (col_r == '0)))
    else $error("column tracker inconsistent with cursor");

  // Every memory write lands inside the screen.
  a_write_range: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (int'(mem_wa) < CELL_COUNT))
    else $error("memory write outside screen");

  // A command is taken from the queue only when idle, and taking one always starts it.
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (state_r != S_IDLE) && (state_r != S_INIT))
    else $error("pop did not start a command");

endmodule

FILE: design/text_console_writer_unit.sv
// The back end runs one command at a time: an ordinary put writes one cell, a tab
// four spaces, a read waits on the registered read port, and a scroll copies every
// row up by one, then zeroes the last row. A clear zeroes every cell in turn.
// Items wait in the queue until the back end has handed the last result to its
// output register. Reset (synchronous, rst_n low) homes the cursor, then a clearing
// pass over all ROWS*COLUMNS cells zeroes the screen while in_stall is held high.
module text_console_writer_unit (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [tcw_pkg::OP_W-1:0]  in_operation,
  input  logic [tcw_pkg::CH_W-1:0]  in_character,
  input  logic [tcw_pkg::CH_W-1:0]  in_colour,
  input  logic [tcw_pkg::IDX_W-1:0] in_cell_index,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [tcw_pkg::CH_W-1:0]  out_cell_character,
  output logic [tcw_pkg::CH_W-1:0]  out_cell_colour,
  output logic [tcw_pkg::IDX_W-1:0] out_cursor_position
);
  import tcw_pkg::*;

  logic q_push;
  logic q_full;
  logic q_pop;
  logic q_empty;
  logic back_init;
  cmd_t push_cmd;
  cmd_t head_cmd;

  // Front end: accepts and classifies items.
  tcw_front u_front (
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_operation  (in_operation),
    .in_character  (in_character),
    .in_colour     (in_colour),
    .in_cell_index (in_cell_index),
    .q_full        (q_full),
    .back_init     (back_init),
    .q_push        (q_push),
    .q_cmd         (push_cmd)
  );

  // Command queue between the two halves.
  tcw_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .head     (head_cmd)
  );

  // Back end: executes commands against the screen memory.
  tcw_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .q_empty             (q_empty),
    .q_head              (head_cmd),
    .q_pop               (q_pop),
    .init_busy           (back_init),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_cell_character  (out_cell_character),
    .out_cell_colour     (out_cell_colour),
    .out_cursor_position (out_cursor_position)
  );

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import tcw_pkg::*;

  // Operation code with no effect on the console.
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  // One result item as the console reports it.
  typedef struct packed {
    logic [CH_W-1:0]  ch;
    logic [CH_W-1:0]  colour;
    logic [IDX_W-1:0] cursor;
  } cell_view_t;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  logic [OP_W-1:0]  in_operation;
  logic [CH_W-1:0]  in_character;
  logic [CH_W-1:0]  in_colour;
  logic [IDX_W-1:0] in_cell_index;
  logic             out_valid;
  logic             out_stall;
  logic [CH_W-1:0]  out_cell_character;
  logic [CH_W-1:0]  out_cell_colour;
  logic [IDX_W-1:0] out_cursor_position;

  // Shadow copy of the screen and cursor, advanced as items are accepted.
  logic [CELL_W-1:0] screen_copy [CELL_COUNT];
  int unsigned       cursor_copy;
  cell_view_t        due_views[$];

  int unsigned sent_items;
  int unsigned checked_views;
  int unsigned scroll_total;
  int unsigned clear_total;
  int unsigned faults;
  int unsigned rx_wait;
  bit          steady;

  text_console_writer_unit dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_operation        (in_operation),
    .in_character        (in_character),
    .in_colour           (in_colour),
    .in_cell_index       (in_cell_index),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_cell_character  (out_cell_character),
    .out_cell_colour     (out_cell_colour),
    .out_cursor_position (out_cursor_position)
  );

  // Clock with a 12 ns period.
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Moves every row up by one when the cursor sits past the last cell.
  function automatic void scroll_if_full();
    int i;
    if (cursor_copy < CELL_COUNT) return;
    for (i = 0; i < CELL_COUNT; i++) begin
      screen_copy[i] = (i + COLUMNS < CELL_COUNT) ? screen_copy[i + COLUMNS] : '0;
    end
    cursor_copy -= COLUMNS;
    scroll_total++;
  endfunction

  // Stores one character at the cursor and advances it.
  function automatic void place_char(logic [CH_W-1:0] ch, logic [CH_W-1:0] colour);
    scroll_if_full();
    if (cursor_copy < CELL_COUNT) begin
      screen_copy[cursor_copy] = {colour, ch};
      cursor_copy++;
    end
  endfunction

  // Applies one item to the shadow console and returns the result it should give.
  function automatic cell_view_t console_step(logic [OP_W-1:0] op, logic [CH_W-1:0] ch,
                                              logic [CH_W-1:0] colour,
                                              logic [IDX_W-1:0] idx);
    cell_view_t view;
    int i;
    view = '0;
    case (op)
      OP_PUT: begin
        if (ch == CH_TAB) begin
          repeat (4) place_char(CH_SPACE, colour);
        end else begin
          scroll_if_full();
          if (ch == CH_NEWLINE) begin
            cursor_copy = cursor_copy + COLUMNS - (cursor_copy % COLUMNS);
            if (cursor_copy > CELL_COUNT) cursor_copy = CELL_COUNT;
          end else if (ch == CH_BACKSPACE) begin
            // At the first cell a backspace leaves everything alone.
            if (cursor_copy > 0) begin
              cursor_copy--;
              screen_copy[cursor_copy] = {colour, CH_SPACE};
            end
          end else begin
            place_char(ch, colour);
          end
        end
      end
      OP_READ: begin
        // Cells past the end of the screen read as zero.
        if (idx < CELL_COUNT) {view.colour, view.ch} = screen_copy[idx];
      end
      OP_CLEAR: begin
        for (i = 0; i < CELL_COUNT; i++) screen_copy[i] = '0;
        cursor_copy = 0;
        clear_total++;
      end
      default: begin
      end
    endcase
    view.cursor = cursor_copy[IDX_W-1:0];
    return view;
  endfunction

  // Records accepted items, checks each result item and paces the result side.
  always @(posedge clk) begin : check_views
    cell_view_t want;
    if (rst_n && in_valid && in_stall === 1'b0) begin
      due_views.push_back(console_step(in_operation, in_character, in_colour,
                                       in_cell_index));
    end
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      checked_views++;
      if (due_views.size() == 0) begin
        faults++;
        if (faults <= 10) begin
          $display("Unexpected result: char %0d colour %0d cursor %0d",
                   out_cell_character, out_cell_colour, out_cursor_position);
        end
      end else begin
        want = due_views.pop_front();
        if (want !== {out_cell_character, out_cell_colour, out_cursor_position}) begin
          faults++;
          if (faults <= 10) begin
            $display("Result %0d: expected char %0d colour %0d cursor %0d, got %0d %0d %0d",
                     checked_views, want.ch, want.colour, want.cursor,
                     out_cell_character, out_cell_colour, out_cursor_position);
          end
        end
      end
      rx_wait = steady ? 0 : $urandom_range(0, 8);
    end else if (rx_wait > 0) begin
      rx_wait--;
    end
    out_stall <= (rx_wait != 0);
  end

  // Presents one item after a random gap and holds it until it is taken.
  task automatic send_item(input logic [OP_W-1:0] op, input logic [CH_W-1:0] ch,
                           input logic [CH_W-1:0] colour, input logic [IDX_W-1:0] idx);
    int unsigned gap;
    gap = steady ? 0 : $urandom_range(0, 8);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_operation  <= op;
    in_character  <= ch;
    in_colour     <= colour;
    in_cell_index <= idx;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    sent_items++;
  endtask

  task automatic put_char(input logic [CH_W-1:0] ch, input logic [CH_W-1:0] colour);
    send_item(OP_PUT, ch, colour, IDX_W'($urandom_range(0, 2047)));
  endtask

  task automatic read_cell(input int unsigned idx);
    send_item(OP_READ, CH_W'($urandom_range(0, 255)), CH_W'($urandom_range(0, 255)),
              IDX_W'(idx));
  endtask

  // Holds the input side quiet until every outstanding result has arrived.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (due_views.size() != 0) @(posedge clk);
  endtask

  // Reads at the screen corners and beyond it, the unused code, and a clear.
  task automatic test_idle_reads();
    read_cell(0);
    read_cell(CELL_COUNT - 1);
    read_cell(CELL_COUNT);
    read_cell(2047);
    send_item(OP_UNUSED, 8'hFF, 8'hFF, 11'h7FF);
    send_item(OP_CLEAR, 8'h00, 8'h00, 11'h000);
  endtask

  // Backspace at the first cell and elsewhere, tab, newline and byte extremes.
  task automatic test_special_chars();
    put_char(CH_BACKSPACE, 8'hAA);
    put_char(8'h00, 8'h00);
    put_char(8'hFF, 8'hFF);
    put_char("X", 8'h55);
    put_char(CH_BACKSPACE, 8'h0F);
    put_char(CH_TAB, 8'hF0);
    put_char(CH_NEWLINE, 8'h00);
    put_char("Z", 8'hC3);
    read_cell(0);
    read_cell(1);
    read_cell(2);
    read_cell(5);
    read_cell(COLUMNS);
    read_cell(COLUMNS + 1);
  endtask

  // Runs the cursor to the bottom row and scrolls through each kind of put.
  task automatic test_scroll();
    int k;
    wait_drained();
    send_item(OP_CLEAR, 8'h00, 8'h00, 11'h000);
    for (k = 0; k < ROWS - 1; k++) put_char(CH_NEWLINE, CH_W'($urandom_range(0, 255)));
    for (k = 0; k < COLUMNS - 2; k++) begin
      put_char(CH_W'($urandom_range(33, 126)), CH_W'($urandom_range(0, 255)));
    end
    // The tab wraps past the last cell and scrolls halfway through.
    put_char(CH_TAB, 8'h1E);
    put_char(CH_BACKSPACE, 8'h2D);
    put_char(CH_NEWLINE, 8'h00);
    for (k = 0; k < 10; k++) read_cell($urandom_range(CELL_COUNT - 3 * COLUMNS, CELL_COUNT - 1));
    put_char("Q", 8'h7A);
    put_char(CH_NEWLINE, 8'h00);
    put_char(CH_NEWLINE, 8'h00);
    put_char(CH_BACKSPACE, 8'h4B);
    put_char(CH_NEWLINE, 8'h00);
    put_char(CH_TAB, 8'h99);
    for (k = 0; k < 10; k++) read_cell($urandom_range(CELL_COUNT - 5 * COLUMNS, CELL_COUNT - 1));
    wait_drained();
  endtask

  // Random text with reads; clears are rare so the screen fills and scrolls.
  task automatic test_random(input int unsigned count);
    int unsigned n;
    int unsigned roll;
    int unsigned back;
    for (n = 0; n < count; n++) begin
      if (n % 64 == 0) steady = ($urandom_range(0, 3) == 0);
      if (n == count / 2) wait_drained();
      roll = $urandom_range(0, 999);
      if (roll < 400) begin
        put_char(CH_W'($urandom_range(32, 126)), CH_W'($urandom_range(0, 255)));
      end else if (roll < 460) begin
        put_char(CH_W'($urandom_range(0, 255)), CH_W'($urandom_range(0, 255)));
      end else if (roll < 510) begin
        put_char(CH_NEWLINE, CH_W'($urandom_range(0, 255)));
      end else if (roll < 570) begin
        put_char(CH_TAB, CH_W'($urandom_range(0, 255)));
      end else if (roll < 650) begin
        put_char(CH_BACKSPACE, CH_W'($urandom_range(0, 255)));
      end else if (roll < 960) begin
        roll = $urandom_range(0, 9);
        back = $urandom_range(1, 2 * COLUMNS);
        if (roll < 4 && cursor_copy > back) read_cell(cursor_copy - back);
        else if (roll < 8) read_cell($urandom_range(0, CELL_COUNT - 1));
        else read_cell($urandom_range(CELL_COUNT, 2047));
      end else if (roll < 995) begin
        send_item(OP_UNUSED, CH_W'($urandom_range(0, 255)), CH_W'($urandom_range(0, 255)),
                  IDX_W'($urandom_range(0, 2047)));
      end else begin
        send_item(OP_CLEAR, CH_W'($urandom_range(0, 255)), CH_W'($urandom_range(0, 255)),
                  IDX_W'($urandom_range(0, 2047)));
      end
    end
    steady = 1'b0;
  endtask

  // Reset, then the tests in turn, then the verdict.
  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_operation  = OP_PUT;
    in_character  = '0;
    in_colour     = '0;
    in_cell_index = '0;
    out_stall     = 1'b0;
    rx_wait       = 0;
    steady        = 1'b0;
    sent_items    = 0;
    checked_views = 0;
    scroll_total  = 0;
    clear_total   = 0;
    faults        = 0;
    cursor_copy   = 0;
    foreach (screen_copy[i]) screen_copy[i] = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    test_idle_reads();
    test_special_chars();
    test_scroll();
    test_random(1300);

    wait_drained();
    repeat (8000) @(posedge clk);
    $display("Sent %0d items and checked %0d results; the screen scrolled %0d times",
             sent_items, checked_views, scroll_total);
    $display("and was cleared %0d times, with %0d failing results.", clear_total, faults);
    if (faults == 0) begin
      $display("text_console_writer_unit: match");
    end else begin
      $display("text_console_writer_unit: mismatch");
    end
    $finish;
  end

  // Watchdog far beyond the slowest expected run, even with a scroll on every item.
  initial begin
    #400_000_000;
    $display("text_console_writer_unit: mismatch");
    $finish;
  end

endmodule
